// ===== sv/sha1s_pkg.sv =====
// Shared types, constants and round functions for the SHA-1 stream hasher.
package sha1s_pkg;

    localparam logic [31:0] SHA1_H0 = 32'h6745_2301;
    localparam logic [31:0] SHA1_H1 = 32'hEFCD_AB89;
    localparam logic [31:0] SHA1_H2 = 32'h98BA_DCFE;
    localparam logic [31:0] SHA1_H3 = 32'h1032_5476;
    localparam logic [31:0] SHA1_H4 = 32'hC3D2_E1F0;

    localparam logic [31:0] SHA1_K0 = 32'h5A82_7999;
    localparam logic [31:0] SHA1_K1 = 32'h6ED9_EBA1;
    localparam logic [31:0] SHA1_K2 = 32'h8F1B_BCDC;
    localparam logic [31:0] SHA1_K3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_BYTE = 8'h80;

    localparam logic [6:0] LAST_ROUND      = 7'd79;
    localparam logic [6:0] LOAD_ROUNDS     = 7'd16;
    localparam logic [3:0] LAST_WORD_IDX   = 4'd15;
    localparam logic [3:0] LEN_HI_WORD_IDX = 4'd14;
    localparam logic [5:0] LEN_FIELD_POS   = 6'd56;
    localparam logic [2:0] LAST_DIGEST_IDX = 3'd4;

    // One 32-bit message word passed from the front end to the compression core
    typedef struct packed {
        logic [31:0] data;
        logic        msg_end;
    } sha1s_word_t;

    typedef enum logic {
        FR_BYTES,
        FR_PAD
    } sha1s_front_state_t;

    typedef enum logic {
        CR_ROUND,
        CR_ADD
    } sha1s_core_state_t;

    function automatic logic [31:0] sha1_f(
        input logic [6:0]  rnd,
        input logic [31:0] b,
        input logic [31:0] c,
        input logic [31:0] d
    );
        logic [31:0] res;
        priority if (rnd < 7'd20)
            res = (b & c) | (~b & d);
        else if (rnd < 7'd40)
            res = b ^ c ^ d;
        else if (rnd < 7'd60)
            res = (b & c) | (b & d) | (c & d);
        else
            res = b ^ c ^ d;
        return res;
    endfunction

    function automatic logic [31:0] sha1_k(input logic [6:0] rnd);
        logic [31:0] res;
        priority if (rnd < 7'd20)
            res = SHA1_K0;
        else if (rnd < 7'd40)
            res = SHA1_K1;
        else if (rnd < 7'd60)
            res = SHA1_K2;
        else
            res = SHA1_K3;
        return res;
    endfunction

endpackage

// ===== sv/sha1s_fifo.sv =====
// Small register-based word queue between the front end and the core.
module sha1s_fifo #(
    parameter int WIDTH = 33,
    parameter int DEPTH = 16
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  logic [WIDTH-1:0] wdata,
    output logic             full,
    input  logic             pop,
    output logic [WIDTH-1:0] rdata,
    output logic             empty
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic             do_push;
    logic             do_pop;

    assign full    = (cnt_reg == CW'(DEPTH));
    assign empty   = (cnt_reg == '0);
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign rdata   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        end
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + CW'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - CW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== sv/sha1s_front.sv =====
// Front end: packs message bytes into words, counts length and generates padding.
module sha1s_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  logic [7:0]            msg_byte,
    input  logic                  has_byte,
    input  logic                  end_of_message,
    output logic                  full,
    input  logic                  q_full,
    output logic                  q_push,
    output sha1s_pkg::sha1s_word_t q_word
);

    import sha1s_pkg::*;

    sha1s_front_state_t state_reg, state_next;
    logic [5:0]  fill_reg, fill_next;
    logic [60:0] count_reg, count_next;
    logic [31:0] word_reg, word_next;
    logic [3:0]  widx_reg, widx_next;
    logic        final_reg, final_next;
    logic        first_reg, first_next;

    logic        accept;
    logic [1:0]  lane;
    logic [4:0]  lane_shift;
    logic [31:0] pad_word;
    logic [5:0]  fill_after;

    assign lane       = fill_reg[1:0];
    assign lane_shift = {lane, 3'b000};
    assign full       = (state_reg != FR_BYTES) || q_full;
    assign accept     = push && !full;

    // Keep the bytes already in the partial word, then the marker byte, then zeros
    assign pad_word = (word_reg & ~(32'hFFFF_FFFF >> lane_shift))
                    | ({PAD_BYTE, 24'h00_0000} >> lane_shift);

    assign fill_after = has_byte ? fill_reg + 6'd1 : fill_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FR_BYTES;
            fill_reg  <= '0;
            count_reg <= '0;
            widx_reg  <= '0;
            final_reg <= 1'b0;
            first_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            fill_reg  <= fill_next;
            count_reg <= count_next;
            widx_reg  <= widx_next;
            final_reg <= final_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        word_reg <= word_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        fill_next      = fill_reg;
        count_next     = count_reg;
        word_next      = word_reg;
        widx_next      = widx_reg;
        final_next     = final_reg;
        first_next     = first_reg;
        q_push         = 1'b0;
        q_word.data    = '0;
        q_word.msg_end = 1'b0;

        unique case (state_reg)
            FR_BYTES:
            begin
                if (accept)
                begin
                    if (has_byte)
                    begin
                        word_next[(5'd24 - lane_shift) +: 8] = msg_byte;
                        fill_next  = fill_reg + 6'd1;
                        count_next = count_reg + 61'd1;
                        if (lane == 2'd3)
                        begin
                            q_push      = 1'b1;
                            q_word.data = word_next;
                        end
                    end
                    if (end_of_message)
                    begin
                        state_next = FR_PAD;
                        widx_next  = fill_after[5:2];
                        final_next = (fill_after < LEN_FIELD_POS);
                        first_next = 1'b1;
                    end
                end
            end
            FR_PAD:
            begin
                if (!q_full)
                begin
                    q_push = 1'b1;
                    priority if (first_reg)
                        q_word.data = pad_word;
                    else if (final_reg && widx_reg == LEN_HI_WORD_IDX)
                        q_word.data = count_reg[60:29];
                    else if (final_reg && widx_reg == LAST_WORD_IDX)
                        q_word.data = {count_reg[28:0], 3'b000};
                    else
                        q_word.data = '0;
                    q_word.msg_end = final_reg && (widx_reg == LAST_WORD_IDX);
                    first_next     = 1'b0;
                    widx_next      = widx_reg + 4'd1;
                    if (widx_reg == LAST_WORD_IDX)
                    begin
                        if (final_reg)
                        begin
                            state_next = FR_BYTES;
                            fill_next  = '0;
                            count_next = '0;
                        end
                        else
                        begin
                            final_next = 1'b1;
                        end
                    end
                end
            end
            default:
            begin
                state_next = FR_BYTES;
            end
        endcase
    end

endmodule

// ===== sv/sha1s_core.sv =====
// Compression core: 80 rounds per block, chaining update and digest word output.
module sha1s_core (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  q_empty,
    input  sha1s_pkg::sha1s_word_t q_word,
    output logic                  q_pop,
    output logic                  empty,
    input  logic                  pop,
    output logic [31:0]           digest_word,
    output logic [2:0]            word_index,
    output logic                  last_word
);

    import sha1s_pkg::*;

    sha1s_core_state_t state_reg, state_next;
    logic [6:0]  rnd_reg, rnd_next;
    logic        msg_reg, msg_next;
    logic [31:0] chain_reg [5];
    logic [31:0] chain_next [5];
    logic [31:0] wk_reg [5];
    logic [31:0] wk_next [5];
    logic [31:0] win_reg [16];
    logic [31:0] win_next [16];
    logic [31:0] dig_reg [5];
    logic [31:0] dig_next [5];
    logic [2:0]  oidx_reg, oidx_next;
    logic        obusy_reg, obusy_next;

    logic [31:0] sa, sb, sc, sd, se;
    logic [31:0] w_in, w_mix, t;
    logic [31:0] sum [5];
    logic        load_phase;
    logic        step;
    logic [31:0] init_words [5];

    assign init_words[0] = SHA1_H0;
    assign init_words[1] = SHA1_H1;
    assign init_words[2] = SHA1_H2;
    assign init_words[3] = SHA1_H3;
    assign init_words[4] = SHA1_H4;

    // First round of a block starts from the chaining value
    assign sa = (rnd_reg == '0) ? chain_reg[0] : wk_reg[0];
    assign sb = (rnd_reg == '0) ? chain_reg[1] : wk_reg[1];
    assign sc = (rnd_reg == '0) ? chain_reg[2] : wk_reg[2];
    assign sd = (rnd_reg == '0) ? chain_reg[3] : wk_reg[3];
    assign se = (rnd_reg == '0) ? chain_reg[4] : wk_reg[4];

    assign load_phase = (rnd_reg < LOAD_ROUNDS);
    assign w_mix      = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_in       = load_phase ? q_word.data : {w_mix[30:0], w_mix[31]};
    assign step       = (state_reg == CR_ROUND) && (!load_phase || !q_empty);
    assign q_pop      = step && load_phase;
    assign t          = {sa[26:0], sa[31:27]} + sha1_f(rnd_reg, sb, sc, sd) + se
                      + sha1_k(rnd_reg) + w_in;

    assign empty       = !obusy_reg;
    assign digest_word = dig_reg[0];
    assign word_index  = oidx_reg;
    assign last_word   = (oidx_reg == LAST_DIGEST_IDX);

    always_comb
    begin
        for (int i = 0; i < 5; i++)
        begin
            sum[i] = chain_reg[i] + wk_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CR_ROUND;
            rnd_reg   <= '0;
            msg_reg   <= 1'b0;
            oidx_reg  <= '0;
            obusy_reg <= 1'b0;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= init_words[i];
            end
        end
        else
        begin
            state_reg <= state_next;
            rnd_reg   <= rnd_next;
            msg_reg   <= msg_next;
            oidx_reg  <= oidx_next;
            obusy_reg <= obusy_next;
            for (int i = 0; i < 5; i++)
            begin
                chain_reg[i] <= chain_next[i];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < 5; i++)
        begin
            wk_reg[i]  <= wk_next[i];
            dig_reg[i] <= dig_next[i];
        end
        for (int i = 0; i < 16; i++)
        begin
            win_reg[i] <= win_next[i];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        rnd_next   = rnd_reg;
        msg_next   = msg_reg;
        oidx_next  = oidx_reg;
        obusy_next = obusy_reg;
        chain_next = chain_reg;
        wk_next    = wk_reg;
        win_next   = win_reg;
        dig_next   = dig_reg;

        unique case (state_reg)
            CR_ROUND:
            begin
                if (step)
                begin
                    wk_next[0] = t;
                    wk_next[1] = sa;
                    wk_next[2] = {sb[1:0], sb[31:2]};
                    wk_next[3] = sc;
                    wk_next[4] = sd;
                    for (int i = 0; i < 15; i++)
                    begin
                        win_next[i] = win_reg[i + 1];
                    end
                    win_next[15] = w_in;
                    rnd_next     = rnd_reg + 7'd1;
                    if (rnd_reg == LOAD_ROUNDS - 7'd1)
                    begin
                        msg_next = q_word.msg_end;
                    end
                    if (rnd_reg == LAST_ROUND)
                    begin
                        state_next = CR_ADD;
                        rnd_next   = '0;
                    end
                end
            end
            CR_ADD:
            begin
                if (!msg_reg)
                begin
                    chain_next = sum;
                    state_next = CR_ROUND;
                end
                else if (!obusy_reg)
                begin
                    // Hand the digest to the output buffer and restart the chain
                    dig_next   = sum;
                    obusy_next = 1'b1;
                    oidx_next  = '0;
                    chain_next = init_words;
                    state_next = CR_ROUND;
                end
            end
            default:
            begin
                state_next = CR_ROUND;
            end
        endcase

        if (pop && obusy_reg)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dig_next[i] = dig_reg[i + 1];
            end
            oidx_next = oidx_reg + 3'd1;
            if (oidx_reg == LAST_DIGEST_IDX)
            begin
                obusy_next = 1'b0;
            end
        end
    end

endmodule

// ===== sv/sha1_stream_hasher.sv =====
// Top level of the SHA-1 stream hasher: front end, word queue and compression core.
//
//  channel | direction | handshake        | transaction
//  --------+-----------+------------------+------------------------------------------
//  input   | in        | push / full      | msg_byte, has_byte, end_of_message
//  result  | out       | pop / empty      | digest_word, word_index, last_word
//
//  Bytes enter at one per cycle until the word queue (QUEUE_DEPTH words) fills; the core
//  runs 80 rounds plus one chaining add per 64-byte block, the first 16 rounds taking
//  words as they arrive, while further words wait in the queue.
//  Closing a message pushes 3 to 18 padding words, one a cycle while the queue has room,
//  and full stays high meanwhile.
//  Reset is asynchronous; the chain starts at the initial hash values, no clearing pass.
//  The core holds in its final add while the previous digest still waits to be popped.
module sha1_stream_hasher #(
    parameter int QUEUE_DEPTH = 16
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  msg_byte,
    input  logic        has_byte,
    input  logic        end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] digest_word,
    output logic [2:0]  word_index,
    output logic        last_word
);

    import sha1s_pkg::*;

    localparam int QW = $bits(sha1s_word_t);

    sha1s_word_t   fe_word;
    sha1s_word_t   be_word;
    logic          fe_push;
    logic          q_full;
    logic          q_empty;
    logic          be_pop;
    logic [QW-1:0] q_rdata;

    assign be_word = q_rdata;

    sha1s_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .push           (push),
        .msg_byte       (msg_byte),
        .has_byte       (has_byte),
        .end_of_message (end_of_message),
        .full           (full),
        .q_full         (q_full),
        .q_push         (fe_push),
        .q_word         (fe_word)
    );

    sha1s_fifo #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (fe_push),
        .wdata (fe_word),
        .full  (q_full),
        .pop   (be_pop),
        .rdata (q_rdata),
        .empty (q_empty)
    );

    sha1s_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_empty),
        .q_word      (be_word),
        .q_pop       (be_pop),
        .empty       (empty),
        .pop         (pop),
        .digest_word (digest_word),
        .word_index  (word_index),
        .last_word   (last_word)
    );

endmodule

// ===== sv/sha1s_checker.sv =====
// Port-level checks on the digest output of the SHA-1 stream hasher, with bind.
module sha1s_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        empty,
    input logic        pop,
    input logic [31:0] digest_word,
    input logic [2:0]  word_index,
    input logic        last_word
);

    // Word index stays within the five digest words
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (word_index <= 3'd4))
        else $error("word_index out of range");

    // The final flag marks exactly the fifth word
    assert property (@(posedge clk) disable iff (!rst_n)
        !empty |-> (last_word == (word_index == 3'd4)))
        else $error("last_word does not match word_index");

    // A stalled digest word holds
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && !pop) |=> (!empty && $stable(digest_word) && $stable(word_index)))
        else $error("digest word changed while stalled");

    // After taking a non-final word, the next word of the digest follows at once
    assert property (@(posedge clk) disable iff (!rst_n)
        (!empty && pop && !last_word) |=>
            (!empty && word_index == $past(word_index) + 3'd1))
        else $error("digest words not delivered in sequence");

endmodule

bind sha1_stream_hasher sha1s_checker u_sha1s_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .empty       (empty),
    .pop         (pop),
    .digest_word (digest_word),
    .word_index  (word_index),
    .last_word   (last_word)
);
